### sv/oli_pkg.sv
// ----------------------------------------------------------------------------
// oli_pkg
// Types, sizes and codes shared by the ordered list files.
// ----------------------------------------------------------------------------
package oli_pkg;

    localparam int CAPACITY    = 64;
    localparam int VALUE_WIDTH = 32;

    localparam int OP_W      = 3;
    localparam int POS_W     = 7;
    localparam int IN_VAL_W  = 32;
    localparam int CNT_OUT_W = 7;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int AT_W      = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    typedef logic [VALUE_WIDTH-1:0] t_val;
    typedef logic [CAPACITY-1:0]    t_mask;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT      = 3'd0,
        OP_APPEND      = 3'd1,
        OP_REMOVE_AT   = 3'd2,
        OP_REMOVE_LAST = 3'd3,
        OP_REMOVE_VAL  = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        CA_HOLD,
        CA_LEFT,
        CA_RIGHT,
        CA_LOAD
    } t_cell_act;

    typedef struct packed {
        t_cell_act act;
        logic      live;
    } t_cell_ctl;

    function automatic t_val to_val(input logic [IN_VAL_W-1:0] x);
        t_val r;
        for (int i = 0; i < VALUE_WIDTH; i++) begin
            r[i] = (i < IN_VAL_W) ? x[i] : 1'b0;
        end
        return r;
    endfunction

    function automatic logic [IN_VAL_W-1:0] to_out(input t_val x);
        logic [IN_VAL_W-1:0] r;
        for (int i = 0; i < IN_VAL_W; i++) begin
            r[i] = (i < VALUE_WIDTH) ? x[i] : 1'b0;
        end
        return r;
    endfunction

endpackage

### sv/oli_if.sv
// ----------------------------------------------------------------------------
// oli_in_if / oli_out_if
// Valid/ready channels for operation beats and result beats.
// ----------------------------------------------------------------------------
interface oli_in_if;
    logic                          valid;
    logic                          ready;
    logic [oli_pkg::OP_W-1:0]      op;
    logic [oli_pkg::POS_W-1:0]     position;
    logic [oli_pkg::IN_VAL_W-1:0]  item_value;

    modport source (output valid, output op, output position, output item_value,
                    input ready);
    modport sink   (input valid, input op, input position, input item_value,
                    output ready);
endinterface

interface oli_out_if;
    logic                           valid;
    logic                           ready;
    logic                           ok;
    logic [oli_pkg::IN_VAL_W-1:0]   removed_value;
    logic [oli_pkg::CNT_OUT_W-1:0]  count;
    logic                           empty_res;

    modport source (output valid, output ok, output removed_value, output count,
                    output empty_res, input ready);
    modport sink   (input valid, input ok, input removed_value, input count,
                    input empty_res, output ready);
endinterface

### sv/oli_cell.sv
// ----------------------------------------------------------------------------
// oli_cell
// One list slot: holds an entry, shifts with its neighbors, flags a match.
// ----------------------------------------------------------------------------
module oli_cell (
    input  logic               i_clk,
    input  oli_pkg::t_cell_ctl i_ctl,
    input  oli_pkg::t_val      i_left,
    input  oli_pkg::t_val      i_right,
    input  oli_pkg::t_val      i_new,
    input  oli_pkg::t_val      i_key,
    output oli_pkg::t_val      o_data,
    output logic               o_match
);
    import oli_pkg::*;

    t_val r_data;
    logic r_match;

    always_ff @(posedge i_clk) begin
        case (i_ctl.act)
            CA_LEFT:  r_data <= i_left;
            CA_RIGHT: r_data <= i_right;
            CA_LOAD:  r_data <= i_new;
            default:  r_data <= r_data;
        endcase
        r_match <= i_ctl.live && (r_data == i_key);
    end

    assign o_data  = r_data;
    assign o_match = r_match;

endmodule

### sv/ordered_list_insert_remove.sv
// ----------------------------------------------------------------------------
// ordered_list_insert_remove
// Ordered list with insert/append/remove-at/remove-last/remove-by-value.
// ----------------------------------------------------------------------------
// One operation beat is handled at a time, in these steps: accept, a cycle
// in which every cell compares its entry with the key, a cycle that resolves
// the target slot and the success flag, and a cycle in which the whole row of
// cells shifts at once and the result beat is registered. The last step waits
// while a previous result beat is still held on the output. Entries are not
// cleared after reset; only slots below the count are ever read.
module ordered_list_insert_remove (
    input  logic       i_clk,
    input  logic       i_rst_n,
    oli_in_if.sink     i_in,
    oli_out_if.source  o_out
);
    import oli_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_MATCH, S_FIND, S_EXEC} t_state;

    t_state               r_state;
    logic [OP_W-1:0]      r_op;
    logic [POS_W-1:0]     r_pos;
    t_val                 r_val;
    logic [CNT_W-1:0]     r_cnt;
    t_mask                r_sel;
    t_mask                r_ge;
    logic                 r_ok;
    logic                 r_ins;
    logic                 r_out_valid;
    logic                 r_out_ok;
    logic [IN_VAL_W-1:0]  r_out_rem;
    logic [CNT_OUT_W-1:0] r_out_cnt;
    logic                 r_out_empty;

    t_val      cell_data  [CAPACITY];
    t_val      cell_left  [CAPACITY];
    t_val      cell_right [CAPACITY];
    t_cell_ctl cell_ctl   [CAPACITY];
    t_mask     match;

    logic             exec_go;
    logic [AT_W-1:0]  pos_ext;
    logic [AT_W-1:0]  cnt_ext;
    logic [AT_W-1:0]  at;
    logic             n_ok;
    logic             n_ins;
    t_mask            n_sel;
    t_mask            n_ge;
    t_mask            lowest;
    t_val             removed;
    logic [CNT_W-1:0] n_cnt;

    assign exec_go = (r_state == S_EXEC) && (!r_out_valid || o_out.ready);

    // target resolution
    always_comb begin
        pos_ext = AT_W'(r_pos);
        cnt_ext = AT_W'(r_cnt);
        lowest  = match & (~match + t_mask'(1));
        at      = '0;
        n_ok    = 1'b0;
        n_ins   = 1'b0;
        case (r_op)
            OP_INSERT: begin
                at    = pos_ext;
                n_ok  = (pos_ext <= cnt_ext) && (r_cnt < CAP_CNT);
                n_ins = 1'b1;
            end
            OP_APPEND: begin
                at    = cnt_ext;
                n_ok  = r_cnt < CAP_CNT;
                n_ins = 1'b1;
            end
            OP_REMOVE_AT: begin
                at   = pos_ext;
                n_ok = pos_ext < cnt_ext;
            end
            OP_REMOVE_LAST: begin
                at   = cnt_ext - AT_W'(1);
                n_ok = r_cnt != '0;
            end
            OP_REMOVE_VAL: begin
                n_ok = |match;
            end
            default: begin
                n_ok = 1'b0;
            end
        endcase
        for (int i = 0; i < CAPACITY; i++) begin
            n_sel[i] = (at == AT_W'(i));
            n_ge[i]  = (AT_W'(i) >= at);
        end
        if (r_op == OP_REMOVE_VAL) begin
            n_sel = lowest;
            n_ge  = ~(lowest - t_mask'(1));
        end
    end

    always_comb begin
        removed = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            removed = removed | (cell_data[i] & {VALUE_WIDTH{r_sel[i]}});
        end
        n_cnt = r_ins ? (r_cnt + CNT_W'(1)) : (r_cnt - CNT_W'(1));
        if (!r_ok) begin
            n_cnt = r_cnt;
        end
    end

    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            cell_ctl[i].live = CNT_W'(i) < r_cnt;
            cell_ctl[i].act  = CA_HOLD;
            if (exec_go && r_ok) begin
                if (r_ins) begin
                    if (r_sel[i]) begin
                        cell_ctl[i].act = CA_LOAD;
                    end else if (r_ge[i]) begin
                        cell_ctl[i].act = CA_LEFT;
                    end
                end else if (r_ge[i]) begin
                    cell_ctl[i].act = CA_RIGHT;
                end
            end
            cell_left[i]  = (i == 0) ? t_val'(0) : cell_data[(i == 0) ? 0 : i - 1];
            cell_right[i] = (i == CAPACITY - 1) ? t_val'(0)
                          : cell_data[(i == CAPACITY - 1) ? i : i + 1];
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        oli_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (cell_ctl[g]),
            .i_left  (cell_left[g]),
            .i_right (cell_right[g]),
            .i_new   (r_val),
            .i_key   (r_val),
            .o_data  (cell_data[g]),
            .o_match (match[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_op    <= i_in.op;
                        r_pos   <= i_in.position;
                        r_val   <= to_val(i_in.item_value);
                        r_state <= S_MATCH;
                    end
                end
                S_MATCH: begin
                    r_state <= S_FIND;
                end
                S_FIND: begin
                    r_sel   <= n_sel;
                    r_ge    <= n_ge;
                    r_ok    <= n_ok;
                    r_ins   <= n_ins;
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    if (exec_go) begin
                        r_cnt   <= n_cnt;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            if (exec_go) begin
                r_out_valid <= 1'b1;
                r_out_ok    <= r_ok;
                r_out_rem   <= (r_ok && !r_ins) ? to_out(removed) : '0;
                r_out_cnt   <= CNT_OUT_W'(n_cnt);
                r_out_empty <= n_cnt == '0;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign i_in.ready          = (r_state == S_IDLE);
    assign o_out.valid         = r_out_valid;
    assign o_out.ok            = r_out_ok;
    assign o_out.removed_value = r_out_rem;
    assign o_out.count         = r_out_cnt;
    assign o_out.empty_res     = r_out_empty;

endmodule

### sv/oli_checker.sv
// ----------------------------------------------------------------------------
// oli_checker
// Port-level checks on the result channel of the ordered list.
// ----------------------------------------------------------------------------
module oli_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          i_ready,
    input logic                          i_ok,
    input logic [oli_pkg::IN_VAL_W-1:0]  i_removed,
    input logic [oli_pkg::CNT_OUT_W-1:0] i_count,
    input logic                          i_empty
);
    import oli_pkg::*;

    // result beat holds until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_ready) |=> i_valid)
        else $error("result beat dropped while stalled");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (i_empty == (i_count == '0)))
        else $error("empty flag disagrees with count");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_ok) |-> (i_removed == '0))
        else $error("failed op reports a removed value");

    a_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (i_count <= CNT_OUT_W'(CAPACITY)))
        else $error("count above capacity");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("result beat right after reset");

endmodule

bind ordered_list_insert_remove oli_checker u_oli_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_valid   (o_out.valid),
    .i_ready   (o_out.ready),
    .i_ok      (o_out.ok),
    .i_removed (o_out.removed_value),
    .i_count   (o_out.count),
    .i_empty   (o_out.empty_res)
);

### sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives operation beats into the ordered list and checks every result beat
// against a shadow list kept in the bench. A directed opening covers empty and
// out-of-range cases and unknown opcodes. Random fill and drain phases follow,
// with random idling on both channels, two long output hold-offs and two
// pauses of the sender until all results are in.
// ----------------------------------------------------------------------------
module tb_top;
    import oli_pkg::*;

    localparam int RANDOM_BEATS = 1850;
    localparam int STALL_LIMIT  = 4000;
    localparam int TAIL_CYCLES  = 16;
    localparam int POOL_DEPTH   = 16;

    localparam logic [OP_W-1:0] OP_BAD_5 = 3'd5;
    localparam logic [OP_W-1:0] OP_BAD_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_BAD_7 = 3'd7;

    typedef struct {
        logic [OP_W-1:0]     op;
        logic [POS_W-1:0]    position;
        logic [IN_VAL_W-1:0] item_value;
        bit                  drain_first;
    } t_op_beat;

    typedef struct {
        logic                 ok;
        logic [IN_VAL_W-1:0]  removed_value;
        logic [CNT_OUT_W-1:0] count;
        logic                 empty_res;
    } t_list_result;

    logic i_clk;
    logic i_rst_n;

    oli_in_if  in_if ();
    oli_out_if out_if ();

    ordered_list_insert_remove DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    t_op_beat     op_beats_q[$];
    t_list_result outcome_q[$];
    t_val         shadow_list[$];
    t_op_beat     cur_beat;
    t_list_result want;

    int error_cnt    = 0;
    int results_seen = 0;
    int send_gap     = 0;
    int recv_gap     = 0;
    int hold_left    = 0;
    int stall_cycles = 0;
    bit send_burst   = 0;
    bit recv_burst   = 0;

    always #4 i_clk = ~i_clk;

    function automatic int draw_gap(input bit burst);
        return burst ? 0 : $urandom_range(0, 10);
    endfunction

    function automatic t_list_result apply_list_op(input t_op_beat b);
        t_list_result r;
        t_val         v;
        int           at;
        int           hit;
        v               = t_val'(b.item_value);
        at              = b.position;
        hit             = -1;
        r.ok            = 1'b0;
        r.removed_value = '0;
        case (b.op)
            OP_INSERT: begin
                if (at <= shadow_list.size() && shadow_list.size() < CAPACITY) begin
                    shadow_list.insert(at, v);
                    r.ok = 1'b1;
                end
            end
            OP_APPEND: begin
                if (shadow_list.size() < CAPACITY) begin
                    shadow_list.push_back(v);
                    r.ok = 1'b1;
                end
            end
            OP_REMOVE_AT: begin
                if (at < shadow_list.size()) begin
                    r.removed_value = IN_VAL_W'(shadow_list[at]);
                    shadow_list.delete(at);
                    r.ok = 1'b1;
                end
            end
            OP_REMOVE_LAST: begin
                if (shadow_list.size() > 0) begin
                    r.removed_value = IN_VAL_W'(shadow_list.pop_back());
                    r.ok = 1'b1;
                end
            end
            OP_REMOVE_VAL: begin
                for (int i = 0; i < shadow_list.size(); i++) begin
                    if (hit < 0 && shadow_list[i] == v) hit = i;
                end
                if (hit >= 0) begin
                    r.removed_value = IN_VAL_W'(shadow_list[hit]);
                    shadow_list.delete(hit);
                    r.ok = 1'b1;
                end
            end
            default: ;
        endcase
        r.count     = CNT_OUT_W'(shadow_list.size());
        r.empty_res = (shadow_list.size() == 0);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [IN_VAL_W-1:0] got_v,
                                   input logic [IN_VAL_W-1:0] exp_v);
        $display("ERROR result %0d %s: got %h exp %h", results_seen, what, got_v, exp_v);
        error_cnt++;
    endtask

    task automatic push_beat(input logic [OP_W-1:0] op, input int pos,
                             input logic [IN_VAL_W-1:0] val, input bit drain);
        t_op_beat b;
        b.op          = op;
        b.position    = POS_W'(pos);
        b.item_value  = val;
        b.drain_first = drain;
        op_beats_q.push_back(b);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                outcome_q.push_back(apply_list_op(cur_beat));
                send_gap = draw_gap(send_burst);
                if ($urandom_range(0, 49) == 0) send_burst = !send_burst;
            end
            if (in_if.valid && !in_if.ready) begin
                // beat held until taken
            end else if (send_gap > 0) begin
                send_gap--;
                in_if.valid <= 1'b0;
            end else if (op_beats_q.size() > 0 &&
                         !(op_beats_q[0].drain_first && outcome_q.size() > 0)) begin
                cur_beat            = op_beats_q.pop_front();
                in_if.valid      <= 1'b1;
                in_if.op         <= cur_beat.op;
                in_if.position   <= cur_beat.position;
                in_if.item_value <= cur_beat.item_value;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (outcome_q.size() == 0) begin
                    report_mismatch("unexpected beat", {31'b0, out_if.ok}, '0);
                end else begin
                    want = outcome_q.pop_front();
                    if (out_if.ok !== want.ok)
                        report_mismatch("ok", {31'b0, out_if.ok}, {31'b0, want.ok});
                    if (out_if.removed_value !== want.removed_value)
                        report_mismatch("removed_value", out_if.removed_value,
                                        want.removed_value);
                    if (out_if.count !== want.count)
                        report_mismatch("count", IN_VAL_W'(out_if.count),
                                        IN_VAL_W'(want.count));
                    if (out_if.empty_res !== want.empty_res)
                        report_mismatch("empty_res", {31'b0, out_if.empty_res},
                                        {31'b0, want.empty_res});
                end
                results_seen++;
                recv_gap = draw_gap(recv_burst);
                if ($urandom_range(0, 49) == 0) recv_burst = !recv_burst;
                if (results_seen == 500 || results_seen == 1400) hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial begin
        t_val            pool[$];
        logic [OP_W-1:0] op;
        logic [IN_VAL_W-1:0] val;
        int              pos;
        int              r;
        int              est;
        int              full_hits;
        bit              filling;

        i_clk            = 1'b0;
        i_rst_n          = 1'b0;
        in_if.valid      = 1'b0;
        in_if.op         = '0;
        in_if.position   = '0;
        in_if.item_value = '0;
        out_if.ready     = 1'b0;

        // empty list, unknown opcodes, out-of-range indexes
        push_beat(OP_REMOVE_LAST, 0, '0, 0);
        push_beat(OP_REMOVE_AT, 0, '0, 0);
        push_beat(OP_REMOVE_VAL, 0, '0, 0);
        push_beat(OP_BAD_5, 0, 32'hFFFF_FFFF, 0);
        push_beat(OP_INSERT, 1, 32'h0000_0001, 0);
        push_beat(OP_APPEND, 0, 32'hFFFF_FFFF, 0);
        push_beat(OP_INSERT, 0, 32'h0000_0000, 0);
        push_beat(OP_INSERT, 2, 32'h8000_0001, 0);
        push_beat(OP_INSERT, 1, 32'h1234_5678, 0);
        push_beat(OP_BAD_6, 127, 32'h5555_5555, 0);
        push_beat(OP_BAD_7, 64, 32'hAAAA_AAAA, 0);
        push_beat(OP_REMOVE_VAL, 0, 32'h0000_0000, 0);
        push_beat(OP_REMOVE_VAL, 0, 32'hDEAD_BEEF, 0);
        push_beat(OP_REMOVE_AT, 127, '0, 0);
        push_beat(OP_INSERT, 127, 32'h0F0F_0F0F, 0);
        push_beat(OP_REMOVE_AT, 3, '0, 0);
        push_beat(OP_INSERT, 4, 32'h0F0F_0F0F, 0);
        push_beat(OP_REMOVE_AT, 1, '0, 0);
        push_beat(OP_REMOVE_VAL, 0, 32'hFFFF_FFFF, 0);
        push_beat(OP_REMOVE_LAST, 0, '0, 0);
        push_beat(OP_REMOVE_LAST, 0, '0, 0);
        push_beat(OP_APPEND, 0, 32'h0000_0000, 1);

        est       = 1;
        full_hits = 0;
        filling   = 1;
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            r = $urandom_range(0, 99);
            if (r < 4) begin
                op = OP_W'($urandom_range(5, 7));
            end else begin
                r = $urandom_range(0, 99);
                if (filling)
                    op = (r < 45) ? OP_INSERT : (r < 75) ? OP_APPEND :
                         (r < 83) ? OP_REMOVE_AT : (r < 90) ? OP_REMOVE_LAST : OP_REMOVE_VAL;
                else
                    op = (r < 10) ? OP_INSERT : (r < 20) ? OP_APPEND :
                         (r < 50) ? OP_REMOVE_AT : (r < 70) ? OP_REMOVE_LAST : OP_REMOVE_VAL;
            end

            if ($urandom_range(0, 9) == 0)
                pos = $urandom_range(0, 127);
            else if (op == OP_INSERT)
                pos = $urandom_range(0, est);
            else
                pos = $urandom_range(0, (est > 0) ? est - 1 : 0);

            r = $urandom_range(0, 9);
            if (op == OP_REMOVE_VAL && pool.size() > 0 && $urandom_range(0, 9) < 7)
                val = IN_VAL_W'(pool[$urandom_range(0, pool.size() - 1)]);
            else if (r == 0)
                val = '0;
            else if (r == 1)
                val = 32'hFFFF_FFFF;
            else if (r < 4)
                val = IN_VAL_W'($urandom_range(0, 7));
            else
                val = $urandom;

            if (op == OP_INSERT || op == OP_APPEND) begin
                pool.push_back(t_val'(val));
                if (pool.size() > POOL_DEPTH) void'(pool.pop_front());
                if (est < CAPACITY) est++;
                else full_hits++;
            end else if (op == OP_REMOVE_AT || op == OP_REMOVE_LAST || op == OP_REMOVE_VAL) begin
                if (est > 0) est--;
            end

            if (filling && full_hits > 20) begin
                filling   = 0;
                full_hits = 0;
            end else if (!filling && est == 0) begin
                filling = 1;
            end else if ($urandom_range(0, 149) == 0) begin
                filling = !filling;
            end

            push_beat(op, pos, val, n == 900);
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (op_beats_q.size() > 0 || in_if.valid) @(posedge i_clk);
        while (outcome_q.size() > 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (error_cnt == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
